/* src/spsq_pkg.sv */
// ----------------------------------------------------------------------------
// spsq_pkg
// types and constants shared by the servo pattern sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package spsq_pkg;

  localparam int unsigned PlanLenDefault = 24;

  localparam logic [15:0] SweepMaxReset  = 16'd135;
  localparam logic [15:0] SweepMinReset  = 16'd45;
  localparam logic [7:0]  InitAngleReset = 8'd90;
  localparam logic [15:0] SweepStep      = 16'd5;
  localparam logic [15:0] OffsetStep     = 16'd5;
  localparam int          WidenLimit     = 175;
  localparam int          NarrowLimit    = 90;

  typedef enum logic [3:0] {
    OP_TICK   = 4'd0,
    OP_SET_A  = 4'd1,
    OP_SET_B  = 4'd2,
    OP_SET_C  = 4'd3,
    OP_ADD_A  = 4'd4,
    OP_ADD_B  = 4'd5,
    OP_ADD_C  = 4'd6,
    OP_INIT   = 4'd7,
    OP_PLAN1  = 4'd8,
    OP_PLAN2  = 4'd9,
    OP_OFFSET = 4'd10,
    OP_WIDEN  = 4'd11,
    OP_NARROW = 4'd12,
    OP_LOAD   = 4'd13
  } spsq_op_e;

  typedef enum logic [1:0] {
    CFG_INIT_A = 2'd0,
    CFG_INIT_B = 2'd1,
    CFG_INIT_C = 2'd2
  } spsq_cfg_e;

  typedef struct packed {
    spsq_op_e           op;
    logic signed [15:0] value;
    logic               plan_sel;
    logic [4:0]         entry;
  } spsq_in_t;

  typedef struct packed {
    logic signed [15:0] angle_a;
    logic signed [15:0] angle_b;
    logic signed [15:0] angle_c;
    logic [1:0]         active_plan;
  } spsq_out_t;

  // word waiting for table data
  typedef struct packed {
    logic        tick;
    logic        zero_c;
    logic [15:0] angle_a;
    logic [15:0] angle_b;
    logic [15:0] angle_c;
    logic [1:0]  active_plan;
  } spsq_s1_t;

endpackage

`default_nettype wire

/* src/spsq_ram.sv */
// ----------------------------------------------------------------------------
// spsq_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module spsq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* src/spsq_ctrl.sv */
// ----------------------------------------------------------------------------
// spsq_ctrl
// command decode, servo and plan state, table access and first stage
// ----------------------------------------------------------------------------
`default_nettype none

module spsq_ctrl #(
  parameter int unsigned PLAN_LEN = spsq_pkg::PlanLenDefault,
  localparam int unsigned NPair   = (PLAN_LEN + 1) / 2,
  localparam int unsigned PairW   = (NPair > 1) ? $clog2(NPair) : 1,
  localparam int unsigned AddrW   = PairW + 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire spsq_pkg::spsq_in_t in_word_i,
  output logic                   in_stall_o,
  input  wire logic              cfg_valid_i,
  input  wire logic [1:0]        cfg_index_i,
  input  wire logic [7:0]        cfg_data_i,
  output logic                   ram_we_o,
  output logic                   ram_wbank_o,
  output logic [AddrW-1:0]       ram_waddr_o,
  output logic [7:0]             ram_wdata_o,
  output logic                   ram_re_o,
  output logic [AddrW-1:0]       ram_raddr_o,
  input  wire logic              s1_ready_i,
  output logic                   s1_valid_o,
  output spsq_pkg::spsq_s1_t     s1_o
);

  logic [2:0][15:0]      servo_q, servo_d;
  logic [1:0]            run_q, run_d;
  logic [1:0][PairW-1:0] pidx_q, pidx_d;
  logic [1:0][15:0]      sweep_q, sweep_d;
  logic [1:0]            up_q, up_d;
  logic [15:0]           offset_q, offset_d;
  logic [15:0]           smax_q, smax_d;
  logic [15:0]           smin_q, smin_d;
  logic [7:0]            init_a_q, init_b_q, init_c_q;
  logic                  s1_valid_q;
  spsq_pkg::spsq_s1_t    s1_q, s1_d;

  logic        load;
  logic        accept;
  logic        is_one;
  logic        ticked;
  logic        plan;
  logic        wrap;
  logic [15:0] sweep_new;
  logic [15:0] val;

  assign load       = !s1_valid_q || s1_ready_i;
  assign in_stall_o = !load;
  assign accept     = in_valid_i && load;
  assign val        = in_word_i.value;
  assign is_one     = (val == 16'd1);
  assign plan       = run_q[1];
  assign wrap       = (pidx_q[plan] == PairW'(NPair - 1));

  // table write, banked by entry parity
  assign ram_we_o    = accept && (in_word_i.op == spsq_pkg::OP_LOAD) &&
                       (32'(in_word_i.entry) < PLAN_LEN);
  assign ram_wbank_o = in_word_i.entry[0];
  assign ram_waddr_o = {in_word_i.plan_sel, PairW'(in_word_i.entry >> 1)};
  assign ram_wdata_o = val[7:0];
  assign ram_raddr_o = {plan, pidx_q[plan]};
  assign ram_re_o    = accept && (in_word_i.op == spsq_pkg::OP_TICK) && (run_q != 2'b00);

  always_comb begin
    servo_d   = servo_q;
    run_d     = run_q;
    pidx_d    = pidx_q;
    sweep_d   = sweep_q;
    up_d      = up_q;
    offset_d  = offset_q;
    smax_d    = smax_q;
    smin_d    = smin_q;
    ticked    = 1'b0;
    sweep_new = sweep_q[plan];
    case (in_word_i.op)
      spsq_pkg::OP_SET_A: servo_d[0] = val;
      spsq_pkg::OP_SET_B: servo_d[1] = val;
      spsq_pkg::OP_SET_C: servo_d[2] = val;
      spsq_pkg::OP_ADD_A: servo_d[0] = servo_q[0] + val;
      spsq_pkg::OP_ADD_B: servo_d[1] = servo_q[1] + val;
      spsq_pkg::OP_ADD_C: servo_d[2] = servo_q[2] + val;
      spsq_pkg::OP_INIT: begin
        servo_d = {{8'd0, init_c_q}, {8'd0, init_b_q}, {8'd0, init_a_q}};
      end
      spsq_pkg::OP_PLAN1, spsq_pkg::OP_PLAN2: begin
        if (is_one) begin
          pidx_d[in_word_i.op == spsq_pkg::OP_PLAN2]  = '0;
          run_d[in_word_i.op == spsq_pkg::OP_PLAN2]   = 1'b1;
          sweep_d[in_word_i.op == spsq_pkg::OP_PLAN2] = servo_q[0];
        end else begin
          pidx_d  = '0;
          run_d   = 2'b00;
          servo_d = {{8'd0, init_c_q}, {8'd0, init_b_q}, {8'd0, init_a_q}};
        end
      end
      spsq_pkg::OP_OFFSET: begin
        offset_d = is_one ? offset_q - spsq_pkg::OffsetStep : offset_q + spsq_pkg::OffsetStep;
      end
      spsq_pkg::OP_WIDEN: begin
        if ($signed(smax_q) <= 16'(spsq_pkg::WidenLimit)) begin
          smax_d = smax_q + spsq_pkg::SweepStep;
          smin_d = smin_q - spsq_pkg::SweepStep;
        end
      end
      spsq_pkg::OP_NARROW: begin
        if ($signed(smax_q) > 16'(spsq_pkg::NarrowLimit)) begin
          smax_d = smax_q - spsq_pkg::SweepStep;
          smin_d = smin_q + spsq_pkg::SweepStep;
        end
      end
      spsq_pkg::OP_TICK: begin
        if (run_q != 2'b00) begin
          ticked = 1'b1;
          if (wrap) begin
            pidx_d[plan] = '0;
            sweep_new    = up_q[plan] ? sweep_q[plan] + 16'd1 : sweep_q[plan] - 16'd1;
            sweep_d[plan] = sweep_new;
            if ($signed(sweep_new) > $signed(smax_q)) begin
              up_d[plan] = 1'b0;
            end
            if ($signed(sweep_new) < $signed(smin_q)) begin
              up_d[plan] = 1'b1;
            end
          end else begin
            pidx_d[plan] = pidx_q[plan] + PairW'(1);
          end
        end
      end
      default: begin
      end
    endcase

    s1_d.tick        = ticked;
    s1_d.zero_c      = ((PLAN_LEN % 2) == 1) && wrap;
    s1_d.angle_a     = ticked ? sweep_new : servo_d[0];
    s1_d.angle_b     = ticked ? offset_q : servo_d[1];
    s1_d.angle_c     = servo_d[2];
    s1_d.active_plan = run_d[1] ? 2'd2 : (run_d[0] ? 2'd1 : 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      servo_q  <= '0;
      run_q    <= '0;
      pidx_q   <= '0;
      sweep_q  <= '0;
      up_q     <= 2'b11;
      offset_q <= '0;
      smax_q   <= spsq_pkg::SweepMaxReset;
      smin_q   <= spsq_pkg::SweepMinReset;
    end else if (accept) begin
      servo_q  <= servo_d;
      run_q    <= run_d;
      pidx_q   <= pidx_d;
      sweep_q  <= sweep_d;
      up_q     <= up_d;
      offset_q <= offset_d;
      smax_q   <= smax_d;
      smin_q   <= smin_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_a_q <= spsq_pkg::InitAngleReset;
      init_b_q <= spsq_pkg::InitAngleReset;
      init_c_q <= spsq_pkg::InitAngleReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        spsq_pkg::CFG_INIT_A: init_a_q <= cfg_data_i;
        spsq_pkg::CFG_INIT_B: init_b_q <= cfg_data_i;
        spsq_pkg::CFG_INIT_C: init_c_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (load) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_o       = s1_q;

endmodule

`default_nettype wire

/* src/spsq_out.sv */
// ----------------------------------------------------------------------------
// spsq_out
// merges table data into the result and holds it in the output register
// ----------------------------------------------------------------------------
`default_nettype none

module spsq_out (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s1_valid_i,
  input  wire spsq_pkg::spsq_s1_t s1_i,
  input  wire logic [7:0]         even_i,
  input  wire logic [7:0]         odd_i,
  output logic                    s1_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output spsq_pkg::spsq_out_t     out_word_o
);

  logic                valid_q;
  spsq_pkg::spsq_out_t word_q, word_d;

  assign s1_ready_o = !valid_q || !out_stall_i;

  always_comb begin
    word_d.angle_a     = s1_i.angle_a;
    word_d.angle_b     = s1_i.tick ? {8'd0, even_i} + s1_i.angle_b : s1_i.angle_b;
    word_d.angle_c     = s1_i.tick ? (s1_i.zero_c ? 16'd0 : {8'd0, odd_i}) : s1_i.angle_c;
    word_d.active_plan = s1_i.active_plan;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s1_ready_o) begin
      valid_q <= s1_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready_o && s1_valid_i) begin
      word_q <= word_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

`default_nettype wire

/* src/servo_pattern_sequencer.sv */
// ----------------------------------------------------------------------------
// servo_pattern_sequencer
// three-servo motion sequencer with two banked plan tables
// ----------------------------------------------------------------------------
// Input words carry a command or a tick; every accepted word gives one result
// word with the three servo angles and the running plan. Both channels move a
// word at a rising edge where valid is high and stall is low.
// out_valid_o rises once the word has passed the first-stage register and the
// output register, which holds it until it is taken.
// One word per cycle is taken while out_stall_i is low: the plan tables sit
// in two rams (even and odd entries), so a tick fetches its servo 2 / servo 3
// pair in one read and the small state registers update in the accept cycle.
// Load words write the table in the accept cycle; a tick in the following
// cycle already reads the new entry.
// When out_stall_i holds, the output register and the stage behind it fill
// and in_stall_o rises once both hold a word.
// Reset clears servo angles, plans, offset and sweep positions and points the
// sweep up; the sweep limits go to 135 and 45 and the initial angles to 90.
// Table entries are undefined until loaded. Config writes are always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_pattern_sequencer #(
  parameter int unsigned PLAN_LEN = spsq_pkg::PlanLenDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire spsq_pkg::spsq_in_t  in_word_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output spsq_pkg::spsq_out_t      out_word_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [7:0]          cfg_data_i
);

  localparam int unsigned NPair = (PLAN_LEN + 1) / 2;
  localparam int unsigned PairW = (NPair > 1) ? $clog2(NPair) : 1;
  localparam int unsigned AddrW = PairW + 1;
  localparam int unsigned Depth = 2 ** AddrW;

  logic               ram_we;
  logic               ram_wbank;
  logic [AddrW-1:0]   ram_waddr;
  logic [7:0]         ram_wdata;
  logic               ram_re;
  logic [AddrW-1:0]   ram_raddr;
  logic [7:0]         even_data;
  logic [7:0]         odd_data;
  logic               s1_valid;
  logic               s1_ready;
  spsq_pkg::spsq_s1_t s1;

  assign cfg_ready_o = 1'b1;

  spsq_ctrl #(
    .PLAN_LEN(PLAN_LEN)
  ) u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_word_i,
    .in_stall_o,
    .cfg_valid_i(cfg_valid_i && cfg_ready_o),
    .cfg_index_i,
    .cfg_data_i,
    .ram_we_o   (ram_we),
    .ram_wbank_o(ram_wbank),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .ram_re_o   (ram_re),
    .ram_raddr_o(ram_raddr),
    .s1_ready_i (s1_ready),
    .s1_valid_o (s1_valid),
    .s1_o       (s1)
  );

  spsq_ram #(
    .WIDTH(8),
    .DEPTH(Depth)
  ) u_ram_even (
    .clk_i,
    .we_i   (ram_we && !ram_wbank),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(even_data)
  );

  spsq_ram #(
    .WIDTH(8),
    .DEPTH(Depth)
  ) u_ram_odd (
    .clk_i,
    .we_i   (ram_we && ram_wbank),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(odd_data)
  );

  spsq_out u_out (
    .clk_i,
    .rst_ni,
    .s1_valid_i (s1_valid),
    .s1_i       (s1),
    .even_i     (even_data),
    .odd_i      (odd_data),
    .s1_ready_o (s1_ready),
    .out_valid_o,
    .out_stall_i,
    .out_word_o
  );

  // input held back only with both stages full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && s1_valid && out_stall_i))
    else $error("input stalled without a full pipeline");

  // one word per cycle: table write and read never coincide
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("table write and read in the same cycle");

  // table data of a waiting tick must not be overwritten by a new read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid && s1.tick && !s1_ready) |=> !$past(ram_re))
    else $error("table read while a tick waits for its data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.active_plan != 2'd3))
    else $error("invalid active plan code");

endmodule

`default_nettype wire
